// ===== hdl/ssd_pkg.sv =====
// Shared types, digit codes and the segment decode table of the seven-segment scan display.
// Depends on nothing; ssd_conv, ssd_scan and the top level import it.
package ssd_pkg;

  localparam int NUM_DIGITS = 6;
  localparam int CODE_W     = 5;
  localparam int FUNC_W     = 3;
  localparam int PERIOD_W   = 8;
  localparam int SLOT_W     = 3;
  localparam int SEG_W      = 8;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CODE_DOT   = code_t'(10);
  localparam code_t CODE_MINUS = code_t'(20);
  localparam code_t CODE_BLANK = code_t'(21);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd50;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK         = 3'd0,
    FUNC_BLANK        = 3'd1,
    FUNC_SIGNED       = 3'd2,
    FUNC_TWO_SIGNED   = 3'd3,
    FUNC_TWO_UNSIGNED = 3'd4,
    FUNC_HUNDREDTHS   = 3'd5
  } func_e;

  // One item leaving the conversion pipeline toward the scan stage.
  typedef struct packed {
    logic                         valid;
    logic [FUNC_W-1:0]            func;
    code_t [NUM_DIGITS-1:0]       codes;
  } conv_out_t;

  // Segment pattern of a digit code, bit 7 is the decimal point.
  function automatic logic [SEG_W-1:0] seg_of(input code_t c);
    logic [SEG_W-1:0] s;
    case (c)
      5'd0:    s = 8'h3f;
      5'd1:    s = 8'h06;
      5'd2:    s = 8'h5b;
      5'd3:    s = 8'h4f;
      5'd4:    s = 8'h66;
      5'd5:    s = 8'h6d;
      5'd6:    s = 8'h7d;
      5'd7:    s = 8'h07;
      5'd8:    s = 8'h7f;
      5'd9:    s = 8'h6f;
      5'd10:   s = 8'hbf;
      5'd11:   s = 8'h86;
      5'd12:   s = 8'hdb;
      5'd13:   s = 8'hcf;
      5'd14:   s = 8'he6;
      5'd15:   s = 8'hed;
      5'd16:   s = 8'hfd;
      5'd17:   s = 8'h87;
      5'd18:   s = 8'hff;
      5'd19:   s = 8'hef;
      5'd20:   s = 8'h40;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/ssd_conv.sv =====
// Input register and binary-to-decimal pipeline that turns set transactions into digit codes.
// Depends on ssd_pkg.
module ssd_conv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  logic [ssd_pkg::FUNC_W-1:0]    func_i,
  input  logic signed [17:0]            value_a_i,
  input  logic signed [10:0]            value_b_i,
  output ssd_pkg::conv_out_t            conv_o
);
  import ssd_pkg::*;

  // Quotient by 10 for values below 100.
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  // Quotient by 100 for values below 1000.
  function automatic logic [3:0] div100(input logic [9:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd41;
    return p[15:12];
  endfunction

  // Stage 0: input register.
  logic              v0_q;
  logic [FUNC_W-1:0] f0_q;
  logic signed [17:0] a0_q;
  logic signed [10:0] b0_q;

  // Stage 1: saturated magnitudes and signs.
  logic              v1_q, v1_d;
  logic [FUNC_W-1:0] f1_q;
  logic              na1_q, na1_d, nb1_q, nb1_d;
  logic [16:0]       ma1_q, ma1_d;
  logic [9:0]        mb1_q, mb1_d;

  // Stage 2: value_a split into thousands and remainder.
  logic              v2_q;
  logic [FUNC_W-1:0] f2_q;
  logic              na2_q, nb2_q;
  logic [6:0]        hi2_q, hi2_d;
  logic [9:0]        lo2_q, lo2_d;
  logic [9:0]        mb2_q;

  // Stage 3: hundreds digits and remainders below 100.
  logic              v3_q;
  logic [FUNC_W-1:0] f3_q;
  logic              na3_q, nb3_q;
  logic [3:0]        ht3_q, ht3_d, hu3_q, hu3_d;
  logic [3:0]        lh3_q, lh3_d, bh3_q, bh3_d;
  logic [6:0]        lr3_q, lr3_d, br3_q, br3_d;

  always_comb begin
    logic signed [17:0] a_lo, a_hi, sa, ma;
    logic signed [10:0] b_lo, b_hi, sb, mb;
    a_lo = '0;
    a_hi = '0;
    b_lo = '0;
    b_hi = '0;
    unique case (f0_q)
      FUNC_SIGNED, FUNC_HUNDREDTHS: begin
        a_lo = -18'sd99999;
        a_hi = 18'sd99999;
      end
      FUNC_TWO_SIGNED: begin
        a_lo = -18'sd99;
        a_hi = 18'sd99;
        b_lo = -11'sd99;
        b_hi = 11'sd99;
      end
      FUNC_TWO_UNSIGNED: begin
        a_hi = 18'sd999;
        b_hi = 11'sd999;
      end
      default: begin
      end
    endcase
    priority if (a0_q > a_hi) sa = a_hi;
    else if (a0_q < a_lo) sa = a_lo;
    else sa = a0_q;
    priority if (b0_q > b_hi) sb = b_hi;
    else if (b0_q < b_lo) sb = b_lo;
    else sb = b0_q;
    ma = sa[17] ? -sa : sa;
    mb = sb[10] ? -sb : sb;
    v1_d  = v0_q;
    na1_d = sa[17];
    nb1_d = sb[10];
    ma1_d = ma[16:0];
    mb1_d = mb[9:0];
  end

  always_comb begin
    logic [27:0] p;
    logic [6:0]  q0;
    logic [16:0] r;
    // The reciprocal underestimates by at most one, so one correction step suffices.
    p  = 28'(ma1_q) * 28'd1048;
    q0 = p[26:20];
    r  = ma1_q - 17'(q0) * 17'd1000;
    if (r[10:0] >= 11'd1000) begin
      hi2_d = q0 + 7'd1;
      lo2_d = 10'(r[10:0] - 11'd1000);
    end else begin
      hi2_d = q0;
      lo2_d = r[9:0];
    end
  end

  always_comb begin
    ht3_d = div10(hi2_q);
    hu3_d = 4'(hi2_q - 7'(ht3_d) * 7'd10);
    lh3_d = div100(lo2_q);
    lr3_d = 7'(lo2_q - 10'(lh3_d) * 10'd100);
    bh3_d = div100(mb2_q);
    br3_d = 7'(mb2_q - 10'(bh3_d) * 10'd100);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= in_valid_i;
      v1_q <= v1_d;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f0_q  <= func_i;
      a0_q  <= value_a_i;
      b0_q  <= value_b_i;
      f1_q  <= f0_q;
      na1_q <= na1_d;
      nb1_q <= nb1_d;
      ma1_q <= ma1_d;
      mb1_q <= mb1_d;
      f2_q  <= f1_q;
      na2_q <= na1_q;
      nb2_q <= nb1_q;
      hi2_q <= hi2_d;
      lo2_q <= lo2_d;
      mb2_q <= mb1_q;
      f3_q  <= f2_q;
      na3_q <= na2_q;
      nb3_q <= nb2_q;
      ht3_q <= ht3_d;
      hu3_q <= hu3_d;
      lh3_q <= lh3_d;
      lr3_q <= lr3_d;
      bh3_q <= bh3_d;
      br3_q <= br3_d;
    end
  end

  // Last step: tens and units of the remainders, then the code layout of each mode.
  always_comb begin
    logic [3:0] lt, lu, bt, bu;
    code_t sign_a, sign_b;
    lt = div10(lr3_q);
    lu = 4'(lr3_q - 7'(lt) * 7'd10);
    bt = div10(br3_q);
    bu = 4'(br3_q - 7'(bt) * 7'd10);
    sign_a = na3_q ? CODE_MINUS : CODE_BLANK;
    sign_b = nb3_q ? CODE_MINUS : CODE_BLANK;
    conv_o.valid = v3_q;
    conv_o.func  = f3_q;
    conv_o.codes = {NUM_DIGITS{CODE_BLANK}};
    unique case (f3_q)
      FUNC_SIGNED, FUNC_HUNDREDTHS: begin
        conv_o.codes[0] = sign_a;
        conv_o.codes[1] = code_t'(ht3_q);
        conv_o.codes[2] = code_t'(hu3_q);
        conv_o.codes[3] = (f3_q == FUNC_HUNDREDTHS) ? code_t'(lh3_q) + CODE_DOT
                                                    : code_t'(lh3_q);
        conv_o.codes[4] = code_t'(lt);
        conv_o.codes[5] = code_t'(lu);
      end
      FUNC_TWO_SIGNED: begin
        conv_o.codes[0] = sign_a;
        conv_o.codes[1] = code_t'(lt);
        conv_o.codes[2] = code_t'(lu);
        conv_o.codes[3] = sign_b;
        conv_o.codes[4] = code_t'(bt);
        conv_o.codes[5] = code_t'(bu);
      end
      FUNC_TWO_UNSIGNED: begin
        conv_o.codes[0] = code_t'(lh3_q);
        conv_o.codes[1] = code_t'(lt);
        conv_o.codes[2] = code_t'(lu);
        conv_o.codes[3] = code_t'(bh3_q);
        conv_o.codes[4] = code_t'(bt);
        conv_o.codes[5] = code_t'(bu);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/ssd_scan.sv =====
// Display state (digit codes, scan slot, indicator timer), period register and output register.
// Depends on ssd_pkg; fed by ssd_conv.
module ssd_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssd_pkg::PERIOD_W-1:0]    cfg_data_i,
  input  ssd_pkg::conv_out_t              conv_i,
  output logic                            adv_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ssd_pkg::SEG_W-1:0]       digit_select_o,
  output logic [ssd_pkg::SEG_W-1:0]       segments_o
);
  import ssd_pkg::*;

  logic [PERIOD_W-1:0]          period_q;
  code_t [NUM_DIGITS-1:0]       codes_q;
  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic [PERIOD_W-1:0]          tick_q, tick_d;
  logic [2:0]                   ind_q, ind_d;
  logic                         out_valid_q;
  logic [SEG_W-1:0]             sel_q, sel_d, seg_q, seg_d;
  logic                         is_tick, is_set;

  // The whole pipeline moves unless a result is held by the receiver.
  assign adv_o   = !out_valid_q || !out_stall_i;
  assign is_tick = conv_i.valid && (conv_i.func == FUNC_TICK);
  assign is_set  = conv_i.valid && (conv_i.func == FUNC_BLANK || conv_i.func == FUNC_SIGNED ||
                   conv_i.func == FUNC_TWO_SIGNED || conv_i.func == FUNC_TWO_UNSIGNED ||
                   conv_i.func == FUNC_HUNDREDTHS);

  always_comb begin
    logic [SLOT_W-1:0] slot;
    slot  = (slot_q == 3'd7) ? 3'd6 : slot_q;
    sel_d = ~(8'd1 << slot);
    if (slot < 3'd6) begin
      seg_d  = seg_of(codes_q[slot]);
      slot_d = slot + 3'd1;
    end else begin
      seg_d  = (ind_q < 3'd6) ? (8'd1 << ind_q) : 8'd0;
      slot_d = '0;
    end
    if (tick_q >= period_q) begin
      tick_d = '0;
      ind_d  = (ind_q >= 3'd5) ? 3'd0 : ind_q + 3'd1;
    end else begin
      tick_d = tick_q + 8'd1;
      ind_d  = ind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      codes_q     <= {NUM_DIGITS{CODE_BLANK}};
      slot_q      <= '0;
      tick_q      <= '0;
      ind_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (adv_o) begin
        out_valid_q <= is_tick;
        if (is_tick) begin
          slot_q <= slot_d;
          tick_q <= tick_d;
          ind_q  <= ind_d;
        end
        if (is_set) begin
          codes_q <= conv_i.codes;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && is_tick) begin
      sel_q <= sel_d;
      seg_q <= seg_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = sel_q;
  assign segments_o     = seg_q;

endmodule

// ===== hdl/seven_segment_scan_display_top.sv =====
// Top level of the six-digit multiplexed seven-segment display driver with indicator slot.
// Depends on ssd_pkg, ssd_conv and ssd_scan.
//
// Each input transaction is either a tick, which yields one output transaction carrying the
// active-low digit select and segment pattern of the current scan slot, or a set command
// (blank, signed integer, two signed, two unsigned, hundredths) that loads new digit codes
// and yields nothing. Slots 0 to 5 show the six digits, slot 6 lights one of six indicator
// LEDs, and the scan then wraps. The lit LED advances every indicator_period+1 ticks.
// The block takes one transaction per clock cycle unless stalled. A transaction goes through
// an input register, three conversion registers (saturation and sign, split by one thousand,
// split by one hundred) and the display state update into the output register. All stages
// move together: while a result sits in the output register and out_stall_i is high,
// in_stall_o is high as well, and otherwise a new transaction is taken every cycle.
// Transactions are handled strictly in order, so a tick that follows a set command shows
// the new digits. The period register is written through the configuration channel,
// which is always ready.
module seven_segment_scan_display_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssd_pkg::PERIOD_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ssd_pkg::FUNC_W-1:0]    func_i,
  input  logic signed [17:0]            value_a_i,
  input  logic signed [10:0]            value_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssd_pkg::SEG_W-1:0]     digit_select_o,
  output logic [ssd_pkg::SEG_W-1:0]     segments_o
);
  import ssd_pkg::*;

  conv_out_t conv;
  logic      adv;

  // The period register can take a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !adv;

  ssd_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .value_a_i  (value_a_i),
    .value_b_i  (value_b_i),
    .conv_o     (conv)
  );

  ssd_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .conv_i         (conv),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_select_o (digit_select_o),
    .segments_o     (segments_o)
  );

  // The input side is held back only by a result that the receiver is holding.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Exactly one scan slot is selected in every result.
  a_one_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot(~digit_select_o) && digit_select_o[7]))
    else $error("digit select is not a single active-low slot");

  // The indicator slot lights at most one of the six LEDs.
  a_indicator : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !digit_select_o[6]) |-> ($onehot0(segments_o) && segments_o[7:6] == 2'b00))
    else $error("indicator slot pattern is not one LED");

endmodule
